// File: sv/hss_pkg.sv
// Package for the Hall-sensor speedometer: state and beep codes, register
// indexes, reset values and timing constants. No dependencies.
package hss_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_FINISH
  } state_e;

  typedef enum logic [2:0] {
    BEEP_NONE   = 3'd0,
    BEEP_ROT    = 3'd1,
    BEEP_ALERT  = 3'd2,
    BEEP_BLINK  = 3'd3,
    BEEP_RESET  = 3'd4
  } beep_e;

  typedef enum logic [2:0] {
    REG_DETECT  = 3'd0,
    REG_RELEASE = 3'd1,
    REG_WHEEL   = 3'd2,
    REG_LIMIT   = 3'd3,
    REG_ROT_GRD = 3'd4,
    REG_STOP    = 3'd5,
    REG_BTN_GRD = 3'd6
  } reg_idx_e;

  localparam logic [9:0]  DetectReset  = 10'd250;
  localparam logic [9:0]  ReleaseReset = 10'd400;
  localparam logic [11:0] WheelReset   = 12'd500;
  localparam logic [15:0] LimitReset   = 16'd150;
  localparam logic [15:0] RotGrdReset  = 16'd100;
  localparam logic [15:0] StopReset    = 16'd3000;
  localparam logic [15:0] BtnGrdReset  = 16'd250;

  localparam logic [31:0] AlertSpacingMs = 32'd1000;
  localparam logic [31:0] BlinkStepMs    = 32'd200;
  localparam logic [8:0]  SpeedScale     = 9'd360;

  // wheel_mm * 360 fits in 21 bits; one quotient bit per divider cycle
  localparam int unsigned NumW     = 21;
  localparam int unsigned DivCntW  = 5;
  localparam logic [DivCntW-1:0] DivLast = DivCntW'(NumW - 1);

endpackage

// File: sv/hall_sensor_speedometer.sv
// Hall-sensor speedometer / odometer top level.
// Uses hss_pkg (state, beep and register codes, constants).
//
// Usage:
//   Input stream (s_axis_*): one request per sensor sample, carrying the
//   sample, the millisecond timestamp and the button level. Each request
//   yields exactly one result on the output stream (m_axis_*): speed in
//   0.01 km/h, distance in mm, LED level and beep code.
//   Config channel (cfg_*): register index and data, always ready; write
//   only while no request is in flight.
//   A sample that counts a rotation passes from accept through the evaluate
//   step, the divider steps and the finish step; the speed quotient comes
//   from a restoring divider retiring one bit per cycle. Other samples go
//   from evaluate straight to finish. One request is in work at a time.
//   The output register holds a result until taken; the next request is
//   accepted meanwhile, and its finish step waits while the output stalls.
//   Reset: configuration returns to its defaults, speed, distance, LED and
//   timers to zero, button history to released. No clearing pass.
module hall_sensor_speedometer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // sample[9:0], now_ms[41:10], button_level[42], zero[47:43]
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // speed_centi_kmh[15:0], distance_mm[47:16], led_on[48], beep_code[51:49],
  // zero[55:52]
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned NumW = hss_pkg::NumW;

  // config
  logic [9:0]  detect_q, release_q;
  logic [11:0] wheel_q;
  logic [15:0] limit_q, rot_grd_q, stop_q, btn_grd_q;

  // block state
  hss_pkg::state_e state_q, state_d;
  logic        magnet_q;
  logic [31:0] last_rot_q, last_alert_q, last_blink_q, last_press_q;
  logic [15:0] speed_q;
  logic [31:0] dist_q;
  logic        phase_q, led_q, btn_prev_q;
  logic        rot_q;

  // request payload and divider
  logic [9:0]  sample_q;
  logic [31:0] now_q;
  logic        button_q;
  logic [31:0] dt_q, rem_q;
  logic [NumW-1:0] num_q;
  logic [hss_pkg::DivCntW-1:0] div_cnt_q;

  // output register
  logic        out_valid_q;
  logic [15:0] out_speed_q;
  logic [31:0] out_dist_q;
  logic        out_led_q;
  hss_pkg::beep_e out_beep_q;

  logic in_acc, fin_go, div_done;
  logic arrival, departure, counted;
  logic [31:0] dt_now;
  logic [32:0] dist_sum;
  logic [32:0] rem_sh;
  logic [33:0] rem_diff;
  logic        rem_ge;

  logic [15:0] speed_div, speed_new;
  logic        over, alert_ok, blink_ok, press_ok;
  hss_pkg::beep_e beep_fin;

  // ---------------- control ----------------
  always_comb begin
    s_axis_tready = (state_q == hss_pkg::ST_IDLE);
    cfg_ready_o   = 1'b1;
    in_acc        = s_axis_tvalid && s_axis_tready;
    div_done      = (state_q == hss_pkg::ST_DIV) && (div_cnt_q == hss_pkg::DivLast);
    fin_go        = (state_q == hss_pkg::ST_FINISH) && (!out_valid_q || m_axis_tready);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      hss_pkg::ST_IDLE:   if (in_acc) state_d = hss_pkg::ST_EVAL;
      hss_pkg::ST_EVAL:   state_d = counted ? hss_pkg::ST_DIV : hss_pkg::ST_FINISH;
      hss_pkg::ST_DIV:    if (div_done) state_d = hss_pkg::ST_FINISH;
      hss_pkg::ST_FINISH: if (fin_go) state_d = hss_pkg::ST_IDLE;
      default:            state_d = hss_pkg::ST_IDLE;
    endcase
  end

  // ---------------- evaluate ----------------
  always_comb begin
    arrival   = (sample_q < detect_q) && !magnet_q;
    departure = !arrival && (sample_q > release_q) && magnet_q;
    dt_now    = now_q - last_rot_q;
    counted   = arrival && (dt_now > {16'd0, rot_grd_q});
    dist_sum  = {1'b0, dist_q} + {21'd0, wheel_q};
  end

  // ---------------- divider step ----------------
  always_comb begin
    rem_sh   = {rem_q, num_q[NumW-1]};
    rem_diff = {1'b0, rem_sh} - {2'b00, dt_q};
    rem_ge   = !rem_diff[33];
  end

  // ---------------- finish ----------------
  always_comb begin
    speed_div = (|num_q[NumW-1:16]) ? 16'hFFFF : num_q[15:0];
    speed_new = rot_q ? speed_div : speed_q;
    if ((now_q - last_rot_q) > {16'd0, stop_q}) speed_new = 16'd0;
    over     = speed_new > limit_q;
    alert_ok = over && ((now_q - last_alert_q) > hss_pkg::AlertSpacingMs);
    blink_ok = over && ((now_q - last_blink_q) > hss_pkg::BlinkStepMs);
    press_ok = !button_q && btn_prev_q && ((now_q - last_press_q) > {16'd0, btn_grd_q});
    beep_fin = rot_q ? hss_pkg::BEEP_ROT : hss_pkg::BEEP_NONE;
    if (alert_ok) beep_fin = hss_pkg::BEEP_ALERT;
    if (blink_ok && !phase_q) beep_fin = hss_pkg::BEEP_BLINK;
    if (press_ok) beep_fin = hss_pkg::BEEP_RESET;
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      detect_q  <= hss_pkg::DetectReset;
      release_q <= hss_pkg::ReleaseReset;
      wheel_q   <= hss_pkg::WheelReset;
      limit_q   <= hss_pkg::LimitReset;
      rot_grd_q <= hss_pkg::RotGrdReset;
      stop_q    <= hss_pkg::StopReset;
      btn_grd_q <= hss_pkg::BtnGrdReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        hss_pkg::REG_DETECT:  detect_q  <= cfg_data_i[9:0];
        hss_pkg::REG_RELEASE: release_q <= cfg_data_i[9:0];
        hss_pkg::REG_WHEEL:   wheel_q   <= cfg_data_i[11:0];
        hss_pkg::REG_LIMIT:   limit_q   <= cfg_data_i;
        hss_pkg::REG_ROT_GRD: rot_grd_q <= cfg_data_i;
        hss_pkg::REG_STOP:    stop_q    <= cfg_data_i;
        hss_pkg::REG_BTN_GRD: btn_grd_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= hss_pkg::ST_IDLE;
      magnet_q     <= 1'b0;
      last_rot_q   <= 32'd0;
      last_alert_q <= 32'd0;
      last_blink_q <= 32'd0;
      last_press_q <= 32'd0;
      speed_q      <= 16'd0;
      dist_q       <= 32'd0;
      phase_q      <= 1'b0;
      led_q        <= 1'b0;
      btn_prev_q   <= 1'b1;
      rot_q        <= 1'b0;
      div_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == hss_pkg::ST_EVAL) begin
        rot_q     <= counted;
        div_cnt_q <= '0;
        if (arrival) magnet_q <= 1'b1;
        else if (departure) magnet_q <= 1'b0;
        if (counted) begin
          dist_q     <= dist_sum[32] ? 32'hFFFF_FFFF : dist_sum[31:0];
          last_rot_q <= now_q;
        end
      end
      if (state_q == hss_pkg::ST_DIV) div_cnt_q <= div_cnt_q + 1'b1;
      if (fin_go) begin
        speed_q <= speed_new;
        if (alert_ok) last_alert_q <= now_q;
        if (blink_ok) begin
          last_blink_q <= now_q;
          phase_q      <= !phase_q;
          led_q        <= !phase_q;
        end else if (!over) begin
          led_q <= 1'b0;
        end
        if (press_ok) begin
          dist_q       <= 32'd0;
          last_press_q <= now_q;
        end
        btn_prev_q <= button_q;
      end
      if (fin_go) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // payload, divider and output data registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= s_axis_tdata[9:0];
      now_q    <= s_axis_tdata[41:10];
      button_q <= s_axis_tdata[42];
    end
    if (state_q == hss_pkg::ST_EVAL) begin
      dt_q  <= dt_now;
      rem_q <= 32'd0;
      num_q <= NumW'({9'd0, wheel_q} * {12'd0, hss_pkg::SpeedScale});
    end else if (state_q == hss_pkg::ST_DIV) begin
      rem_q <= rem_ge ? rem_diff[31:0] : rem_sh[31:0];
      num_q <= {num_q[NumW-2:0], rem_ge};
    end
    if (fin_go) begin
      out_speed_q <= speed_new;
      out_dist_q  <= press_ok ? 32'd0 : dist_q;
      out_led_q   <= blink_ok ? !phase_q : (over ? led_q : 1'b0);
      out_beep_q  <= beep_fin;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_beep_q, out_led_q, out_dist_q, out_speed_q};

`ifndef SYNTHESIS
  a_div_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hss_pkg::ST_DIV) |-> (rem_q < dt_q))
    else $error("divider remainder not below divisor");

  a_div_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hss_pkg::ST_DIV) |-> (div_cnt_q <= hss_pkg::DivLast))
    else $error("divider count out of range");

  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == hss_pkg::ST_EVAL))
    else $error("accepted request not evaluated");

  a_led_overspeed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_led_q) |-> (out_speed_q > limit_q))
    else $error("LED lit without overspeed");

  a_div_only_rot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hss_pkg::ST_DIV) |-> rot_q)
    else $error("divider running without counted rotation");
`endif

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Testbench for hall_sensor_speedometer: streams sensor requests, predicts each
// dashboard readout in step with the accepted requests and checks every result.
// Depends on hss_pkg (beep and register codes) and the RTL top level.
module tb;

  localparam logic [2:0] RegUnmapped = 3'd7;
  localparam logic [31:0] AlertGapMs = 32'd1000;
  localparam logic [31:0] BlinkGapMs = 32'd200;
  localparam int WatchdogLimit = 2000;

  typedef struct packed {
    logic [9:0]  det_level;
    logic [9:0]  rel_level;
    logic [11:0] wheel;
    logic [15:0] limit;
    logic [15:0] rot_guard;
    logic [15:0] stop_to;
    logic [15:0] btn_guard;
  } settings_t;

  typedef struct packed {
    logic        magnet;
    logic [31:0] last_rot;
    logic [15:0] speed;
    logic [31:0] distance;
    logic [31:0] last_alert;
    logic [31:0] last_blink;
    logic        phase;
    logic        btn_prev;
    logic [31:0] last_press;
    logic        led;
  } odo_state_t;

  typedef struct packed {
    logic [15:0]    speed;
    logic [31:0]    distance;
    logic           led;
    hss_pkg::beep_e beep;
  } readout_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  settings_t   settings;
  odo_state_t  odo;
  readout_t    readout_q[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  int          ready_left = 0;
  logic        ready_hold = 1'b1;
  logic [31:0] ride_ms = 32'd200;

  hall_sensor_speedometer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic advance_cyclometer(input logic [9:0] hall, input logic [31:0] now,
                                    input logic button);
    readout_t       r;
    logic [31:0]    dt;
    logic [31:0]    num;
    logic [31:0]    quo;
    hss_pkg::beep_e beep;
    beep = hss_pkg::BEEP_NONE;
    if (hall < settings.det_level && !odo.magnet) begin
      dt = now - odo.last_rot;
      odo.magnet = 1'b1;
      if (dt > {16'd0, settings.rot_guard}) begin
        num = {20'd0, settings.wheel} * 32'd360;
        quo = num / dt;
        odo.speed = (quo > 32'h0000_FFFF) ? 16'hFFFF : quo[15:0];
        if (odo.distance > 32'hFFFF_FFFF - {20'd0, settings.wheel})
          odo.distance = 32'hFFFF_FFFF;
        else
          odo.distance = odo.distance + {20'd0, settings.wheel};
        odo.last_rot = now;
        beep = hss_pkg::BEEP_ROT;
      end
    end else if (hall > settings.rel_level && odo.magnet) begin
      odo.magnet = 1'b0;
    end
    dt = now - odo.last_rot;
    if (dt > {16'd0, settings.stop_to}) odo.speed = '0;
    if (odo.speed > settings.limit) begin
      dt = now - odo.last_alert;
      if (dt > AlertGapMs) begin
        beep = hss_pkg::BEEP_ALERT;
        odo.last_alert = now;
      end
      dt = now - odo.last_blink;
      if (dt > BlinkGapMs) begin
        odo.last_blink = now;
        odo.phase = ~odo.phase;
        odo.led = odo.phase;
        if (odo.phase) beep = hss_pkg::BEEP_BLINK;
      end
    end else begin
      odo.led = 1'b0;
    end
    if (!button && odo.btn_prev) begin
      dt = now - odo.last_press;
      if (dt > {16'd0, settings.btn_guard}) begin
        odo.distance = '0;
        odo.last_press = now;
        beep = hss_pkg::BEEP_RESET;
      end
    end
    odo.btn_prev = button;
    r.speed = odo.speed;
    r.distance = odo.distance;
    r.led = odo.led;
    r.beep = beep;
    readout_q.push_back(r);
  endtask

  task automatic send_sample(input logic [9:0] hall, input logic [31:0] now,
                             input logic button);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 25) : $urandom_range(0, 3);
      burst_left = $urandom_range(1, 40);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'd0, button, now, hall};
    do @(posedge clk_i); while (!s_axis_tready);
    advance_cyclometer(hall, now, button);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (readout_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      hss_pkg::REG_DETECT:  settings.det_level = data[9:0];
      hss_pkg::REG_RELEASE: settings.rel_level = data[9:0];
      hss_pkg::REG_WHEEL:   settings.wheel = data[11:0];
      hss_pkg::REG_LIMIT:   settings.limit = data;
      hss_pkg::REG_ROT_GRD: settings.rot_guard = data;
      hss_pkg::REG_STOP:    settings.stop_to = data;
      hss_pkg::REG_BTN_GRD: settings.btn_guard = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic void flag_mismatch(string what, longint unsigned want,
                                        longint unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0d, got %0d", what, want, got);
  endfunction

  // receiver stalls on its own pattern
  always @(negedge clk_i) begin
    if (ready_left == 0) begin
      ready_hold = ($urandom_range(0, 2) != 0);
      ready_left = ready_hold ? $urandom_range(1, 40) : $urandom_range(1, 12);
    end
    ready_left--;
    m_axis_tready <= ready_hold;
  end

  always @(posedge clk_i) begin
    readout_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (readout_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with no request pending: %h", m_axis_tdata);
      end else begin
        want = readout_q.pop_front();
        if (m_axis_tdata[15:0] !== want.speed)
          flag_mismatch("speed", 64'(want.speed), 64'(m_axis_tdata[15:0]));
        if (m_axis_tdata[47:16] !== want.distance)
          flag_mismatch("distance", 64'(want.distance), 64'(m_axis_tdata[47:16]));
        if (m_axis_tdata[48] !== want.led)
          flag_mismatch("led", 64'(want.led), 64'(m_axis_tdata[48]));
        if (m_axis_tdata[51:49] !== want.beep)
          flag_mismatch("beep", 64'(want.beep), 64'(m_axis_tdata[51:49]));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("hall_sensor_speedometer verification failed");
        $finish;
      end
    end
  end

  task automatic test_directed_defaults();
    send_sample(10'd1023, 32'd0, 1'b1);
    send_sample(10'd0, 32'd50, 1'b1);      // arrival inside guard
    send_sample(10'd100, 32'd60, 1'b1);
    send_sample(10'd401, 32'd70, 1'b1);    // departure
    send_sample(10'd249, 32'd101, 1'b1);   // first counted rotation, overspeed
    send_sample(10'd400, 32'd350, 1'b1);   // blink on
    send_sample(10'd401, 32'd1200, 1'b0);  // alert, blink off, button clears
    send_sample(10'd250, 32'd1300, 1'b1);  // level equal to detect: no arrival
    send_sample(10'd0, 32'd1450, 1'b0);    // press inside button guard
    send_sample(10'd1023, 32'd1460, 1'b1);
    send_sample(10'd0, 32'd1461, 1'b1);
    send_sample(10'd1023, 32'd5000, 1'b1); // stop timeout
  endtask

  task automatic test_register_extremes();
    wait_drained();
    cfg_write(hss_pkg::REG_DETECT, 16'hFFFF);
    cfg_write(hss_pkg::REG_RELEASE, 16'h0000);
    cfg_write(hss_pkg::REG_WHEEL, 16'hFFFF);
    cfg_write(hss_pkg::REG_LIMIT, 16'h0000);
    cfg_write(hss_pkg::REG_ROT_GRD, 16'h0000);
    cfg_write(hss_pkg::REG_STOP, 16'hFFFF);
    cfg_write(hss_pkg::REG_BTN_GRD, 16'h0000);
    cfg_write(RegUnmapped, 16'h5A5A);
    send_sample(10'd500, 32'd5001, 1'b1);        // counted rotation, over the zero limit
    send_sample(10'd500, 32'd5001, 1'b1);        // overlapping levels
    send_sample(10'd500, 32'd5001, 1'b1);        // zero interval
    send_sample(10'd1023, 32'd5002, 1'b1);
    send_sample(10'd0, 32'hFFFF_FFFF, 1'b0);
    send_sample(10'd1023, 32'd0, 1'b1);          // time wraps
    send_sample(10'd0, 32'd5, 1'b1);
    wait_drained();
    cfg_write(hss_pkg::REG_WHEEL, 16'h0000);
    cfg_write(hss_pkg::REG_LIMIT, 16'hFFFF);
    cfg_write(hss_pkg::REG_BTN_GRD, 16'hFFFF);
    send_sample(10'd1023, 32'd10, 1'b1);
    send_sample(10'd0, 32'd20, 1'b1);            // zero wheel rotation
    send_sample(10'd1023, 32'd30, 1'b0);
    wait_drained();
    cfg_write(hss_pkg::REG_ROT_GRD, 16'hFFFF);
    cfg_write(hss_pkg::REG_STOP, 16'h0000);
    cfg_write(hss_pkg::REG_DETECT, 16'h0000);
    cfg_write(hss_pkg::REG_RELEASE, 16'h03FF);
    send_sample(10'd0, 32'd100, 1'b1);
    send_sample(10'd1023, 32'd200, 1'b1);
  endtask

  task automatic pick_settings(input bit wild);
    wait_drained();
    if (wild) begin
      cfg_write(hss_pkg::REG_DETECT, 16'($urandom_range(0, 65535)));
      cfg_write(hss_pkg::REG_RELEASE, 16'($urandom_range(0, 65535)));
      cfg_write(hss_pkg::REG_WHEEL, 16'($urandom_range(0, 65535)));
      cfg_write(hss_pkg::REG_LIMIT, 16'($urandom_range(0, 65535)));
      cfg_write(hss_pkg::REG_ROT_GRD, 16'($urandom_range(0, 65535)));
      cfg_write(hss_pkg::REG_STOP, 16'($urandom_range(0, 65535)));
      cfg_write(hss_pkg::REG_BTN_GRD, 16'($urandom_range(0, 65535)));
    end else begin
      cfg_write(hss_pkg::REG_DETECT, 16'($urandom_range(50, 500)));
      if ($urandom_range(0, 3) == 0)
        cfg_write(hss_pkg::REG_RELEASE, 16'($urandom_range(0, 1023)));
      else
        cfg_write(hss_pkg::REG_RELEASE, 16'($urandom_range(settings.det_level, 1000)));
      cfg_write(hss_pkg::REG_WHEEL, 16'($urandom_range(800, 2500)));
      cfg_write(hss_pkg::REG_LIMIT, 16'($urandom_range(100, 3000)));
      cfg_write(hss_pkg::REG_ROT_GRD, 16'($urandom_range(0, 300)));
      cfg_write(hss_pkg::REG_STOP, 16'($urandom_range(500, 5000)));
      cfg_write(hss_pkg::REG_BTN_GRD, 16'($urandom_range(0, 500)));
    end
    if ($urandom_range(0, 1) == 0) cfg_write(RegUnmapped, 16'($urandom_range(0, 65535)));
  endtask

  task automatic ride(input int items, input bit with_pause);
    int          period;
    int          pos;
    int          adv_ms;
    int          press_left;
    logic [9:0]  hall;
    logic        button;
    period = $urandom_range(150, 2500);
    pos = 0;
    press_left = 0;
    case ($urandom_range(0, 3))
      0: ride_ms = $urandom();
      1: ride_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
      default: ;
    endcase
    for (int k = 0; k < items; k++) begin
      if (with_pause && k == items / 2) wait_drained();
      if ($urandom_range(0, 49) == 0) period = $urandom_range(120, 2500);
      adv_ms = $urandom_range(1, 40);
      if ($urandom_range(0, 79) == 0) adv_ms = $urandom_range(3000, 70000);
      ride_ms = ride_ms + adv_ms;
      if ($urandom_range(0, 99) == 0) ride_ms = ride_ms - $urandom_range(0, 500);
      pos = (pos + adv_ms) % period;
      if ($urandom_range(0, 19) == 0)
        hall = 10'($urandom_range(0, 1023));
      else if (pos < 45)
        hall = 10'($urandom_range(0, (settings.det_level > 0) ? settings.det_level - 1 : 0));
      else
        hall = 10'($urandom_range((settings.rel_level < 1023) ? settings.rel_level + 1 : 1023,
                                  1023));
      if (press_left == 0 && $urandom_range(0, 29) == 0) press_left = $urandom_range(1, 5);
      button = (press_left == 0);
      if (press_left > 0) press_left--;
      send_sample(hall, ride_ms, button);
    end
  endtask

  task automatic test_random_rides();
    for (int p = 0; p < 5; p++) begin
      pick_settings(p == 2);
      ride(125, p == 1);
    end
  endtask

  task automatic test_sensor_noise();
    pick_settings(1'b0);
    for (int k = 0; k < 100; k++)
      send_sample(10'($urandom_range(0, 1023)), $urandom(), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    settings = '{det_level: 10'd250, rel_level: 10'd400, wheel: 12'd500, limit: 16'd150,
                 rot_guard: 16'd100, stop_to: 16'd3000, btn_guard: 16'd250};
    odo = '0;
    odo.btn_prev = 1'b1;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_defaults();
    test_register_extremes();
    test_random_rides();
    test_sensor_noise();

    wait_drained();
    repeat (30) @(posedge clk_i);
    if (mismatches == 0 && readout_q.size() == 0)
      $display("hall_sensor_speedometer verification clean");
    else
      $display("hall_sensor_speedometer verification failed");
    $finish;
  end
endmodule
